// File: rtl/core/fbc_pkg.sv
// Shared constants and types of the frustum box culling block.
package fbc_pkg;

  localparam int CoordBits = 16;
  localparam int NumPlanes = 6;
  localparam int NumAxes   = 3;
  localparam int PartW     = 16;
  localparam int PlaneW    = 64;
  localparam int AddrW     = 6;
  localparam int IdxW      = 3;
  localparam int OffShift  = 14;
  localparam int ProdW     = CoordBits + PartW;
  localparam int OffW      = PartW + OffShift;
  localparam int DistW     = ((ProdW > OffW) ? ProdW : OffW) + 2;

  localparam logic [IdxW-1:0] OffSlot = IdxW'(3);

  typedef logic [CoordBits-1:0] coord_t;
  typedef coord_t [NumAxes-1:0] corner_t;
  typedef logic [NumPlanes-1:0][PlaneW-1:0] plane_set_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } fbc_adv_t;

endpackage

// File: rtl/core/frustum_box_cull.sv
// Top level of the frustum box culling pipeline.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_stall_o   min_x_i .. max_z_i
//  output    out        out_valid_o / out_stall_i visible_o
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// One box enters per cycle while in_stall_o is low; it then passes the select,
// multiply, sum and output register stages before its result appears.
// Reset clears the planes and all valid bits; every box is then visible.
// A stall on the output only holds stages that are full, so bubbles close up.
module frustum_box_cull (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fbc_pkg::CoordBits-1:0] min_x_i,
  input  logic [fbc_pkg::CoordBits-1:0] min_y_i,
  input  logic [fbc_pkg::CoordBits-1:0] min_z_i,
  input  logic [fbc_pkg::CoordBits-1:0] max_x_i,
  input  logic [fbc_pkg::CoordBits-1:0] max_y_i,
  input  logic [fbc_pkg::CoordBits-1:0] max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          visible_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbc_pkg::AddrW-1:0]     paddr,
  input  logic [fbc_pkg::PlaneW-1:0]    pwdata,
  output logic [fbc_pkg::PlaneW-1:0]    prdata,
  output logic                          pready
);

  fbc_pkg::plane_set_t           planes;
  fbc_pkg::corner_t              lo;
  fbc_pkg::corner_t              hi;
  fbc_pkg::fbc_adv_t             adv;
  logic [fbc_pkg::NumPlanes-1:0] behind;
  logic                          v1_q, v2_q, v3_q;
  logic                          out_valid_q;
  logic                          visible_q;
  logic                          out_rdy;

  fbc_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .planes_o (planes)
  );

  assign lo = {min_z_i, min_y_i, min_x_i};
  assign hi = {max_z_i, max_y_i, max_x_i};

  assign out_rdy   = !out_valid_q || !out_stall_i;
  assign adv.s3_en = !v3_q || out_rdy;
  assign adv.s2_en = !v2_q || adv.s3_en;
  assign adv.s1_en = !v1_q || adv.s2_en;
  assign in_stall_o = !adv.s1_en;

  for (genvar p = 0; p < fbc_pkg::NumPlanes; p++) begin : g_lane
    fbc_plane_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .plane_i  (planes[p]),
      .lo_i     (lo),
      .hi_i     (hi),
      .behind_o (behind[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv.s1_en) begin
        v1_q <= in_valid_i;
      end
      if (adv.s2_en) begin
        v2_q <= v1_q;
      end
      if (adv.s3_en) begin
        v3_q <= v2_q;
      end
      if (out_rdy) begin
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      visible_q <= ~|behind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

endmodule

// File: rtl/core/fbc_cfg_regs.sv
// APB register file that holds the six frustum planes.
module fbc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbc_pkg::AddrW-1:0]     paddr,
  input  logic [fbc_pkg::PlaneW-1:0]    pwdata,
  output logic [fbc_pkg::PlaneW-1:0]    prdata,
  output logic                          pready,
  output fbc_pkg::plane_set_t           planes_o
);

  logic [fbc_pkg::IdxW-1:0] idx;
  logic                     idx_ok;
  logic                     wr_en;
  fbc_pkg::plane_set_t      plane_q;

  assign idx    = paddr[fbc_pkg::AddrW-1:fbc_pkg::AddrW-fbc_pkg::IdxW];
  assign idx_ok = (idx < fbc_pkg::IdxW'(fbc_pkg::NumPlanes));
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (wr_en) begin
      plane_q[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = plane_q[idx];
    end
  end

  assign planes_o = plane_q;

endmodule

// File: rtl/core/fbc_plane_lane.sv
// Three-stage distance test of a box against one plane.
module fbc_plane_lane (
  input  logic                          clk_i,
  input  fbc_pkg::fbc_adv_t             adv_i,
  input  logic [fbc_pkg::PlaneW-1:0]    plane_i,
  input  fbc_pkg::corner_t              lo_i,
  input  fbc_pkg::corner_t              hi_i,
  output logic                          behind_o
);

  fbc_pkg::corner_t                                   pick_d;
  fbc_pkg::corner_t                                   pick_q;
  logic signed [fbc_pkg::NumAxes-1:0][fbc_pkg::ProdW-1:0] prod_q;
  logic signed [fbc_pkg::DistW-1:0]                   dist_sum;
  logic signed [fbc_pkg::PartW-1:0]                   offset;
  logic                                               behind_q;

  // The farthest corner along the normal is picked per axis, so one sum covers all eight.
  always_comb begin
    logic signed [fbc_pkg::PartW-1:0] n;
    logic                             lo_gt;
    for (int a = 0; a < fbc_pkg::NumAxes; a++) begin
      n     = plane_i[fbc_pkg::PartW*a +: fbc_pkg::PartW];
      lo_gt = ($signed(lo_i[a]) > $signed(hi_i[a]));
      if (n[fbc_pkg::PartW-1]) begin
        pick_d[a] = lo_gt ? hi_i[a] : lo_i[a];
      end else begin
        pick_d[a] = lo_gt ? lo_i[a] : hi_i[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1_en) begin
      pick_q <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2_en) begin
      for (int a = 0; a < fbc_pkg::NumAxes; a++) begin
        prod_q[a] <= $signed(pick_q[a]) *
                     $signed(plane_i[fbc_pkg::PartW*a +: fbc_pkg::PartW]);
      end
    end
  end

  assign offset = plane_i[fbc_pkg::PartW*fbc_pkg::OffSlot +: fbc_pkg::PartW];

  always_comb begin
    dist_sum = fbc_pkg::DistW'($signed(prod_q[0])) + fbc_pkg::DistW'($signed(prod_q[1]))
             + fbc_pkg::DistW'($signed(prod_q[2]))
             + (fbc_pkg::DistW'(offset) <<< fbc_pkg::OffShift);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3_en) begin
      behind_q <= dist_sum[fbc_pkg::DistW-1];
    end
  end

  assign behind_o = behind_q;

endmodule

// File: rtl/core/frustum_box_cull_chk.sv
// Port-level checker of the frustum box culling block and its bind.
module frustum_box_cull_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          visible_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [fbc_pkg::AddrW-1:0]     paddr,
  input logic [fbc_pkg::PlaneW-1:0]    pwdata,
  input logic [fbc_pkg::PlaneW-1:0]    prdata
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled output transaction was dropped.");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(visible_o))
    else $error("Stalled output payload changed.");

  // With no output stall, an accepted box comes out once it has passed every pipeline stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("Result did not appear after the pipeline latency.");

  // A write to plane 0 is read back on the next cycle.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == '0) ##1 (paddr == '0)
    |-> prdata == $past(pwdata))
    else $error("Plane register read-back mismatch.");

endmodule

bind frustum_box_cull frustum_box_cull_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .visible_o   (visible_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

// File: tb/sv/tb_frustum_box_cull.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frustum box culling block with its own plane test model.
module tb_frustum_box_cull;
  import fbc_pkg::*;

  localparam int ResetCycles = 6;
  localparam int MaxIdle = 16;
  localparam int SettleCycles = 10;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;
  localparam int RegStride = 8;
  localparam int RegSlots = 8;
  localparam int NumCorners = 1 << NumAxes;
  localparam int OneQ14 = 1 << OffShift;
  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;
  localparam int CubeHalf = 'h400;
  localparam logic [3:0][PlaneW-1:0] ExtremePlanes = {
    64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000
  };

  typedef enum int {
    PlaneNear, PlaneFar, PlaneTop, PlaneBottom, PlaneLeft, PlaneRight
  } plane_e;

  typedef struct packed {
    corner_t lo;
    corner_t hi;
  } box_t;

  typedef struct {
    box_t        box;
    int unsigned gap;
  } box_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  box_t tx_box = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic visible_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [PlaneW-1:0] pwdata = '0;
  logic [PlaneW-1:0] prdata;
  logic pready;

  plane_set_t plane_regs = '0;
  box_item_t box_q[$];
  logic visible_exp_q[$];
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold_cycles = 0;
  bit rx_burst = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned boxes_checked = 0;
  int unsigned boxes_culled = 0;
  int unsigned reg_writes = 0;

  frustum_box_cull i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .min_x_i     (tx_box.lo[AxisX]),
    .min_y_i     (tx_box.lo[AxisY]),
    .min_z_i     (tx_box.lo[AxisZ]),
    .max_x_i     (tx_box.hi[AxisX]),
    .max_y_i     (tx_box.hi[AxisY]),
    .max_z_i     (tx_box.hi[AxisZ]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic box_visible(box_t b);
    longint nrm [NumAxes];
    longint off;
    longint dsum;
    logic all_out;
    for (int p = 0; p < NumPlanes; p++) begin
      for (int a = 0; a < NumAxes; a++) begin
        nrm[a] = longint'($signed(plane_regs[p][PartW*a +: PartW]));
      end
      off = longint'($signed(plane_regs[p][PartW*int'(OffSlot) +: PartW])) * OneQ14;
      all_out = 1'b1;
      for (int c = 0; c < NumCorners; c++) begin
        dsum = off;
        for (int a = 0; a < NumAxes; a++) begin
          dsum += nrm[a] * longint'($signed(c[a] ? b.hi[a] : b.lo[a]));
        end
        if (dsum >= 0) all_out = 1'b0;
      end
      if (all_out) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int inward_dir(int p, int a);
    int ax;
    int s;
    case (p)
      PlaneNear: begin
        ax = AxisZ;
        s = 1;
      end
      PlaneFar: begin
        ax = AxisZ;
        s = -1;
      end
      PlaneTop: begin
        ax = AxisY;
        s = -1;
      end
      PlaneBottom: begin
        ax = AxisY;
        s = 1;
      end
      PlaneLeft: begin
        ax = AxisX;
        s = 1;
      end
      default: begin
        ax = AxisX;
        s = -1;
      end
    endcase
    return (a == ax) ? s : 0;
  endfunction

  function automatic logic [PlaneW-1:0] frustum_plane(int p, int half, int unsigned jitter);
    logic [PlaneW-1:0] v;
    int n;
    v = '0;
    for (int a = 0; a < NumAxes; a++) begin
      n = (jitter == 0) ? 0 : int'($urandom_range(0, 2 * jitter)) - int'(jitter);
      n += inward_dir(p, a) * OneQ14;
      v[PartW*a +: PartW] = PartW'(n);
    end
    v[PartW*int'(OffSlot) +: PartW] = PartW'(half);
    return v;
  endfunction

  function automatic int unsigned idle_len(bit burst);
    return burst ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  function automatic box_t random_box(int unsigned span, int unsigned hs);
    box_t b;
    int ctr;
    int half;
    coord_t t;
    bit noise;
    noise = (span == 0) || ($urandom_range(0, 9) == 0);
    for (int a = 0; a < NumAxes; a++) begin
      if (noise) begin
        b.lo[a] = coord_t'($urandom);
        b.hi[a] = coord_t'($urandom);
      end else begin
        ctr = int'($urandom_range(0, 2 * span)) - int'(span);
        half = int'($urandom_range(0, hs));
        b.lo[a] = coord_t'(ctr - half);
        b.hi[a] = coord_t'(ctr + half);
        if ($urandom_range(0, 15) == 0) begin
          t = b.lo[a];
          b.lo[a] = b.hi[a];
          b.hi[a] = t;
        end
      end
    end
    return b;
  endfunction

  // Sender: presents queued boxes and records the expected verdict on each transaction.
  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    box_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        visible_exp_q.push_back(box_visible(tx_box));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_wait != 0) begin
          in_valid_i <= 1'b0;
          tx_wait <= tx_wait - 1;
        end else if (box_q.size() != 0) begin
          nxt = box_q.pop_front();
          tx_box <= nxt.box;
          in_valid_i <= 1'b1;
          tx_wait <= nxt.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and draws its own stall per result.
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int unsigned nw;
    logic exp_vis;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait <= 0;
    end else begin
      nw = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        boxes_checked++;
        if (!visible_o) boxes_culled++;
        if (visible_exp_q.size() == 0) begin
          $error("visible: no result expected, got %0b", visible_o);
          mismatch_count++;
        end else begin
          exp_vis = visible_exp_q.pop_front();
          if (visible_o !== exp_vis) begin
            $error("visible: expected %0b, got %0b", exp_vis, visible_o);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        nw = idle_len(rx_burst);
      end else if (rx_wait != 0) begin
        nw = rx_wait - 1;
      end
      rx_wait <= nw;
      out_stall_i <= (nw != 0) || (rx_hold_cycles != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold_cycles != 0) rx_hold_cycles <= rx_hold_cycles - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_xfer(input bit wr, input int idx, input logic [PlaneW-1:0] wdata,
                          output logic [PlaneW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= AddrW'(idx * RegStride);
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic plane_readback(int idx);
    logic [PlaneW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== plane_regs[idx]) begin
      $error("prdata: expected %h, got %h", plane_regs[idx], rd);
      mismatch_count++;
    end
  endtask

  task automatic plane_write(int idx, logic [PlaneW-1:0] value);
    logic [PlaneW-1:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    reg_writes++;
    if (idx < NumPlanes) begin
      plane_regs[idx] = value;
      plane_readback(idx);
    end
  endtask

  // The queues and the valid are looked at between edges, where every update has settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (box_q.size() != 0 || in_valid_i || visible_exp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_box(box_t b);
    box_q.push_back('{box: b, gap: idle_len(1'b0)});
  endtask

  task automatic queue_boxes(int n, int unsigned span, int unsigned hs);
    bit burst;
    burst = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      box_q.push_back('{box: random_box(span, hs), gap: idle_len(burst)});
    end
    wait_drained();
  endtask

  initial begin : stimulus
    box_t b;
    box_t inner;
    int s;
    int half;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With all planes at zero every distance is zero, so every box is visible.
    for (int p = 0; p < NumPlanes; p++) plane_readback(p);
    b.lo = {NumAxes{coord_t'(16'h8000)}};
    b.hi = {NumAxes{coord_t'(16'h8000)}};
    push_box(b);
    b.lo = {NumAxes{coord_t'(16'h7FFF)}};
    b.hi = {NumAxes{coord_t'(16'h7FFF)}};
    push_box(b);
    b.hi = {NumAxes{coord_t'(16'h8000)}};
    push_box(b);
    b.lo = {NumAxes{coord_t'(16'h8000)}};
    b.hi = {NumAxes{coord_t'(16'h7FFF)}};
    push_box(b);
    wait_drained();

    // Axis-aligned cube frustum: an inner box, boxes outside, and touching at zero distance, per plane.
    for (int p = 0; p < NumPlanes; p++) plane_write(p, frustum_plane(p, CubeHalf, 0));
    inner.lo = {NumAxes{coord_t'(-CubeHalf / 2)}};
    inner.hi = {NumAxes{coord_t'(CubeHalf / 2)}};
    push_box(inner);
    b.lo = inner.hi;
    b.hi = inner.lo;
    push_box(b);
    for (int p = 0; p < NumPlanes; p++) begin
      for (int a = 0; a < NumAxes; a++) begin
        s = inward_dir(p, a);
        b = inner;
        if (s > 0) begin
          b.lo[a] = coord_t'(-3 * CubeHalf);
          b.hi[a] = coord_t'(-CubeHalf - 1);
          push_box(b);
          b.hi[a] = coord_t'(-CubeHalf);
          push_box(b);
        end else if (s < 0) begin
          b.lo[a] = coord_t'(CubeHalf + 1);
          b.hi[a] = coord_t'(3 * CubeHalf);
          push_box(b);
          b.lo[a] = coord_t'(CubeHalf);
          push_box(b);
        end
      end
    end
    b.lo = {NumAxes{coord_t'(16'h8000)}};
    b.hi = {NumAxes{coord_t'(16'h8000)}};
    push_box(b);
    b.lo = {NumAxes{coord_t'(16'h7FFF)}};
    b.hi = {NumAxes{coord_t'(16'h7FFF)}};
    push_box(b);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering boxes.
    rx_hold_cycles <= HoldCycles;
    queue_boxes(60, 2 * CubeHalf, CubeHalf / 2);
    queue_boxes(150, 2 * CubeHalf, CubeHalf / 2);

    for (int k = 0; k < 4; k++) begin
      for (int p = 0; p < NumPlanes; p++) plane_write(p, ExtremePlanes[(p + k) % 4]);
      queue_boxes(40, 0, 0);
    end

    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) begin
        half = int'($urandom_range(16, 6000));
        for (int p = 0; p < NumPlanes; p++) plane_write(p, frustum_plane(p, half, 2048));
        queue_boxes(45, 2 * half, half / 2 + 1);
      end else begin
        for (int p = 0; p < NumPlanes; p++) plane_write(p, {$urandom, $urandom});
        queue_boxes(45, 0, 0);
      end
      if (k == 3) begin
        // Writes to the unused register slots must leave the planes alone.
        for (int i = NumPlanes; i < RegSlots; i++) plane_write(i, {$urandom, $urandom});
        queue_boxes(40, 2 * half, half / 2 + 1);
      end
    end

    wait_drained();
    $display("Summary: %0d boxes checked, %0d culled, over %0d register writes.",
             boxes_checked, boxes_culled, reg_writes);
    if (mismatch_count == 0 && visible_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/fbc_pkg.sv
rtl/core/fbc_cfg_regs.sv
rtl/core/fbc_plane_lane.sv
rtl/core/frustum_box_cull.sv
rtl/core/frustum_box_cull_chk.sv
tb/sv/tb_frustum_box_cull.sv
